>>> src/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg: shared types and constants for the load cell serial reader
// Register map, reset values, saturation limits and the per-tick flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

   // Configuration register map
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_TARE_DEPOSIT  = 2'd0;
   localparam logic [1:0] REG_TARE_REWARD   = 2'd1;
   localparam logic [1:0] REG_INVERSE_SCALE = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

   // Field widths fixed by the interface
   localparam int TARE_WIDTH    = 24;
   localparam int SCALE_WIDTH   = 32;
   localparam int TIMEOUT_WIDTH = 24;
   localparam int RAW_WIDTH     = 24;
   localparam int SCALED_WIDTH  = 32;
   localparam int SCALE_FRAC    = 16;

   // Register reset values
   localparam logic [TARE_WIDTH-1:0]    TARE_RESET    = '0;
   localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET   = 32'd65536;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 24'd200000;

   // Signed 32-bit saturation limits
   localparam logic [SCALED_WIDTH-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [SCALED_WIDTH-1:0] SAT_MIN = 32'h8000_0000;

   // Control flags produced by the sequencer for one tick
   typedef struct packed {
      logic sck;
      logic busy;
      logic done;
      logic tmo;
   } flags_type;

endpackage

`default_nettype wire

>>> src/load_cell_adc_serial_reader_unit.sv
// Each request passes the sequencer, multiply and saturate stages in order.
// Throughput: one request per cycle unless the response side stalls; the
// multiply and saturate steps follow the tick sequencer as two more stages.
// Reset (synchronous, active high) returns the sequencer to idle, empties the
// pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_unit: serial reader for a 24-bit bridge converter
// Each request is one half-period tick of the converter's serial clock. The
// unit waits for data ready, clocks out the conversion MSB first, adds the
// gain-128 pulse, and reports raw and scaled (tare-corrected) readings.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_adc_serial_reader_unit #(
   parameter int DATA_BITS = 24
) (
   input  wire                                     clock,
   input  wire                                     reset,

   // Tick requests
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire                                     req_type,
   input  wire                                     req_sensor_select,
   input  wire                                     req_data_level,

   // Tick responses
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic                                    rsp_serial_clock,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic                                    rsp_timed_out,
   output logic signed [lcr_pkg::RAW_WIDTH-1:0]     rsp_raw_value,
   output logic signed [lcr_pkg::SCALED_WIDTH-1:0]  rsp_scaled_value,

   // Configuration port
   input  wire                                     csr_psel,
   input  wire                                     csr_penable,
   input  wire                                     csr_pwrite,
   input  wire         [lcr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire         [lcr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic        [lcr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                    csr_pready
);

   // Difference of raw word and tare needs one bit beyond the wider of the two
   localparam int RW         = (DATA_BITS > lcr_pkg::RAW_WIDTH) ? DATA_BITS
                                                                 : lcr_pkg::RAW_WIDTH;
   localparam int DIFF_WIDTH = RW + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [lcr_pkg::TARE_WIDTH-1:0]    tare_deposit_ff;
   logic signed [lcr_pkg::TARE_WIDTH-1:0]    tare_reward_ff;
   logic        [lcr_pkg::SCALE_WIDTH-1:0]   inverse_scale_ff;
   logic        [lcr_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks_ff;

   logic [1:0] csr_index;
   logic       csr_write;

   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Write on the access phase; unused upper data bits drop
   always_ff @(posedge clock) begin
      if (reset) begin
         tare_deposit_ff  <= lcr_pkg::TARE_RESET;
         tare_reward_ff   <= lcr_pkg::TARE_RESET;
         inverse_scale_ff <= lcr_pkg::SCALE_RESET;
         timeout_ticks_ff <= lcr_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lcr_pkg::REG_TARE_DEPOSIT:  tare_deposit_ff  <= csr_pwdata[lcr_pkg::TARE_WIDTH-1:0];
            lcr_pkg::REG_TARE_REWARD:   tare_reward_ff   <= csr_pwdata[lcr_pkg::TARE_WIDTH-1:0];
            lcr_pkg::REG_INVERSE_SCALE: inverse_scale_ff <= csr_pwdata;
            lcr_pkg::REG_TIMEOUT_TICKS:
               timeout_ticks_ff <= csr_pwdata[lcr_pkg::TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read back the stored value, zero-extended to the bus
   always_comb begin
      case (csr_index)
         lcr_pkg::REG_TARE_DEPOSIT:  csr_prdata = 32'(unsigned'(tare_deposit_ff));
         lcr_pkg::REG_TARE_REWARD:   csr_prdata = 32'(unsigned'(tare_reward_ff));
         lcr_pkg::REG_INVERSE_SCALE: csr_prdata = inverse_scale_ff;
         lcr_pkg::REG_TIMEOUT_TICKS: csr_prdata = 32'(timeout_ticks_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage 1: tick sequencer, registers flags, raw word and difference
   // ------------------------------------------------------------------
   logic                                   a_valid;
   logic                                   a_ready;
   lcr_pkg::flags_type                     a_flags;
   logic signed [lcr_pkg::RAW_WIDTH-1:0]   a_raw;
   logic signed [DIFF_WIDTH-1:0]           a_diff;

   lcr_fsm #(
      .DATA_BITS  (DATA_BITS),
      .DIFF_WIDTH (DIFF_WIDTH)
   ) u_fsm (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_sensor_select (req_sensor_select),
      .req_data_level    (req_data_level),
      .tare_deposit      (tare_deposit_ff),
      .tare_reward       (tare_reward_ff),
      .timeout_ticks     (timeout_ticks_ff),
      .down_ready        (a_ready),
      .a_valid           (a_valid),
      .a_flags           (a_flags),
      .a_raw             (a_raw),
      .a_diff            (a_diff)
   );

   // ------------------------------------------------------------------
   // Stages 2 and 3: multiply, then floor and saturate into the response
   // register; each stage holds while the next is full and stalled
   // ------------------------------------------------------------------
   lcr_pkg::flags_type rsp_flags;

   lcr_scale #(
      .DIFF_WIDTH (DIFF_WIDTH)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .a_valid       (a_valid),
      .a_ready       (a_ready),
      .a_flags       (a_flags),
      .a_raw         (a_raw),
      .a_diff        (a_diff),
      .inverse_scale (inverse_scale_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_flags     (rsp_flags),
      .rsp_raw       (rsp_raw_value),
      .rsp_scaled    (rsp_scaled_value)
   );

   assign rsp_serial_clock = rsp_flags.sck;
   assign rsp_busy_res     = rsp_flags.busy;
   assign rsp_done_res     = rsp_flags.done;
   assign rsp_timed_out    = rsp_flags.tmo;

endmodule

`default_nettype wire

>>> src/lcr_fsm.sv
// ----------------------------------------------------------------------------
// lcr_fsm: tick sequencer
// Runs the wait / clock-out / gain-pulse sequence, one tick per request, and
// registers flags, raw word and tare-corrected difference for the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_fsm #(
   parameter int DATA_BITS  = 24,
   parameter int DIFF_WIDTH = 25
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire                                     req_type,
   input  wire                                     req_sensor_select,
   input  wire                                     req_data_level,
   input  wire  signed [lcr_pkg::TARE_WIDTH-1:0]    tare_deposit,
   input  wire  signed [lcr_pkg::TARE_WIDTH-1:0]    tare_reward,
   input  wire         [lcr_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks,
   input  wire                                     down_ready,
   output logic                                    a_valid,
   output lcr_pkg::flags_type                      a_flags,
   output logic signed [lcr_pkg::RAW_WIDTH-1:0]     a_raw,
   output logic signed [DIFF_WIDTH-1:0]            a_diff
);

   localparam int RW  = (DATA_BITS > lcr_pkg::RAW_WIDTH) ? DATA_BITS : lcr_pkg::RAW_WIDTH;
   localparam int PCW = $clog2(DATA_BITS + 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WAIT = 3'd1,
      PH_HIGH = 3'd2,
      PH_LOW  = 3'd3,
      PH_GAIN = 3'd4
   } phase_type;

   phase_type                          phase_ff,  phase_in;
   logic [PCW-1:0]                     count_ff,  count_in;
   logic [DATA_BITS-1:0]               shift_ff,  shift_in;
   logic [lcr_pkg::TIMEOUT_WIDTH-1:0]  wait_ff,   wait_in;
   logic                               sensor_ff, sensor_in;

   logic                               a_valid_ff;
   lcr_pkg::flags_type                 flags_ff,  flags_in;
   logic signed [lcr_pkg::RAW_WIDTH-1:0] raw_ff;
   logic signed [DIFF_WIDTH-1:0]       diff_ff,   diff_in;

   logic                               a_ready;
   logic                               accept;
   logic signed [RW-1:0]               raw_in;
   logic signed [lcr_pkg::TARE_WIDTH-1:0] tare_sel;

   assign a_ready   = !a_valid_ff || down_ready;
   assign req_ready = a_ready;
   assign accept    = req_valid && a_ready;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      wait_in   = wait_ff;
      sensor_in = sensor_ff;
      flags_in  = '0;
      raw_in    = '0;
      case (phase_ff)
         PH_WAIT: begin
            if (!req_data_level) begin
               phase_in     = PH_HIGH;
               flags_in.sck = 1'b1;
            end else if (wait_ff >= timeout_ticks) begin
               phase_in      = PH_IDLE;
               flags_in.done = 1'b1;
               flags_in.tmo  = 1'b1;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         PH_HIGH: begin
            shift_in = {shift_ff[DATA_BITS-2:0], req_data_level};
            count_in = count_ff + 1'b1;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            flags_in.sck = 1'b1;
            phase_in     = (count_ff < PCW'(DATA_BITS)) ? PH_HIGH : PH_GAIN;
         end
         PH_GAIN: begin
            phase_in      = PH_IDLE;
            flags_in.done = 1'b1;
            raw_in        = RW'($signed(shift_ff));
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_type) begin
               sensor_in = req_sensor_select;
               count_in  = '0;
               shift_in  = '0;
               wait_in   = '0;
               phase_in  = PH_WAIT;
            end
         end
      endcase
      flags_in.busy = (phase_in != PH_IDLE);
   end

   assign tare_sel = sensor_ff ? tare_reward : tare_deposit;
   assign diff_in  = flags_in.done ? (DIFF_WIDTH'(raw_in) - DIFF_WIDTH'(tare_sel)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         shift_ff   <= '0;
         wait_ff    <= '0;
         sensor_ff  <= 1'b0;
         a_valid_ff <= 1'b0;
         flags_ff   <= '0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            shift_ff  <= shift_in;
            wait_ff   <= wait_in;
            sensor_ff <= sensor_in;
         end
         if (a_ready) begin
            a_valid_ff <= req_valid;
            flags_ff   <= flags_in;
            raw_ff     <= raw_in[lcr_pkg::RAW_WIDTH-1:0];
            diff_ff    <= diff_in;
         end
      end
   end

   assign a_valid = a_valid_ff;
   assign a_flags = flags_ff;
   assign a_raw   = raw_ff;
   assign a_diff  = diff_ff;

endmodule

`default_nettype wire

>>> src/lcr_scale.sv
// ----------------------------------------------------------------------------
// lcr_scale: fixed-point scaler and response register
// Multiplies the tare-corrected difference by the Q16.16 reciprocal scale,
// floors by 2^16 and saturates to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_scale #(
   parameter int DIFF_WIDTH = 25
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     a_valid,
   output logic                                    a_ready,
   input  lcr_pkg::flags_type                      a_flags,
   input  wire  signed [lcr_pkg::RAW_WIDTH-1:0]     a_raw,
   input  wire  signed [DIFF_WIDTH-1:0]            a_diff,
   input  wire         [lcr_pkg::SCALE_WIDTH-1:0]   inverse_scale,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output lcr_pkg::flags_type                      rsp_flags,
   output logic signed [lcr_pkg::RAW_WIDTH-1:0]     rsp_raw,
   output logic signed [lcr_pkg::SCALED_WIDTH-1:0]  rsp_scaled
);

   localparam int PW = DIFF_WIDTH + lcr_pkg::SCALE_WIDTH + 1;
   localparam int SW = PW - lcr_pkg::SCALE_FRAC;

   logic                                   b_valid_ff;
   lcr_pkg::flags_type                     b_flags_ff;
   logic signed [lcr_pkg::RAW_WIDTH-1:0]   b_raw_ff;
   logic signed [PW-1:0]                   prod_ff, prod_in;

   logic                                   o_valid_ff;
   lcr_pkg::flags_type                     o_flags_ff;
   logic signed [lcr_pkg::RAW_WIDTH-1:0]   o_raw_ff;
   logic signed [lcr_pkg::SCALED_WIDTH-1:0] o_scaled_ff, o_scaled_in;

   logic                                   b_ready;
   logic                                   o_ready;
   logic signed [SW-1:0]                   floored;
   logic [SW-lcr_pkg::SCALED_WIDTH:0]      upper;
   logic                                   fits;

   assign o_ready = !o_valid_ff || rsp_ready;
   assign b_ready = !b_valid_ff || o_ready;
   assign a_ready = b_ready;

   assign prod_in = PW'(a_diff) * PW'($signed({1'b0, inverse_scale}));

   // Upper bits of the product are the floor of product / 2^16
   assign floored = prod_ff[PW-1:lcr_pkg::SCALE_FRAC];
   assign upper   = floored[SW-1:lcr_pkg::SCALED_WIDTH-1];
   assign fits    = (&upper) || !(|upper);
   assign o_scaled_in = fits ? floored[lcr_pkg::SCALED_WIDTH-1:0]
                           : (floored[SW-1] ? lcr_pkg::SAT_MIN : lcr_pkg::SAT_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         b_flags_ff <= '0;
         o_flags_ff <= '0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= a_valid;
            b_flags_ff <= a_flags;
            b_raw_ff   <= a_raw;
            prod_ff    <= prod_in;
         end
         if (o_ready) begin
            o_valid_ff  <= b_valid_ff;
            o_flags_ff  <= b_flags_ff;
            o_raw_ff    <= b_raw_ff;
            o_scaled_ff <= o_scaled_in;
         end
      end
   end

   assign rsp_valid  = o_valid_ff;
   assign rsp_flags  = o_flags_ff;
   assign rsp_raw    = o_raw_ff;
   assign rsp_scaled = o_scaled_ff;

endmodule

`default_nettype wire

>>> src/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker: port-level checks for the load cell serial reader
// Watches the response channel for flag consistency and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    rsp_valid,
   input wire                                    rsp_ready,
   input wire                                    rsp_busy_res,
   input wire                                    rsp_done_res,
   input wire                                    rsp_timed_out,
   input wire [lcr_pkg::RAW_WIDTH-1:0]            rsp_raw_value,
   input wire [lcr_pkg::SCALED_WIDTH-1:0]         rsp_scaled_value
);

   // A finished read always returns the sequencer to idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done response reports busy");

   // Timeout comes only with done, and carries a zero raw value
   a_timeout_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_done_res && (rsp_raw_value == '0))
      else $error("timeout without done or with nonzero raw value");

   // Ticks that finish nothing carry no reading
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> (rsp_raw_value == '0) && (rsp_scaled_value == '0))
      else $error("reading reported on a tick without done");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled_value))
      else $error("response dropped or changed while stalled");

endmodule

bind load_cell_adc_serial_reader_unit lcr_checker u_lcr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res),
   .rsp_timed_out    (rsp_timed_out),
   .rsp_raw_value    (rsp_raw_value),
   .rsp_scaled_value (rsp_scaled_value)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the load cell serial reader unit
// Feeds half-period ticks (start requests, data line levels) through the
// request channel, predicts every per-tick response in step with accepted
// requests, and checks responses field by field while both sides stall.
// ----------------------------------------------------------------------------

module tb;

   // Request kinds and sensor selects
   localparam logic TICK_PLAIN     = 1'b0;
   localparam logic TICK_START     = 1'b1;
   localparam logic SENSOR_DEPOSIT = 1'b0;
   localparam logic SENSOR_REWARD  = 1'b1;

   localparam int WORD_BITS      = 24;
   localparam int RANDOM_PHASES  = 3;
   localparam int PHASE_BUDGET   = 40;

   // Sequencer states of the predicted reader
   typedef enum logic [2:0] {
      RD_IDLE,
      RD_WAIT,
      RD_HIGH,
      RD_LOW,
      RD_GAIN
   } reader_state_type;

   typedef struct packed {
      logic kind;
      logic sensor;
      logic level;
   } tick_type;

   typedef struct packed {
      logic                             sck;
      logic                             busy;
      logic                             done;
      logic                             tmo;
      logic [lcr_pkg::RAW_WIDTH-1:0]    raw;
      logic [lcr_pkg::SCALED_WIDTH-1:0] scaled;
   } reading_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // Request channel
   logic req_valid         = 1'b0;
   logic req_type          = TICK_PLAIN;
   logic req_sensor_select = SENSOR_DEPOSIT;
   logic req_data_level    = 1'b1;
   logic req_ready;

   // Response channel
   logic                                    rsp_ready = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_serial_clock;
   logic                                    rsp_busy_res;
   logic                                    rsp_done_res;
   logic                                    rsp_timed_out;
   logic signed [lcr_pkg::RAW_WIDTH-1:0]    rsp_raw_value;
   logic signed [lcr_pkg::SCALED_WIDTH-1:0] rsp_scaled_value;

   // Configuration port
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [lcr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [lcr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [lcr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   load_cell_adc_serial_reader_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_sensor_select (req_sensor_select),
      .req_data_level    (req_data_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_serial_clock  (rsp_serial_clock),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_scaled_value  (rsp_scaled_value),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Register copies, updated as each write completes
   logic signed [lcr_pkg::TARE_WIDTH-1:0] tare_deposit_q = lcr_pkg::TARE_RESET;
   logic signed [lcr_pkg::TARE_WIDTH-1:0] tare_reward_q  = lcr_pkg::TARE_RESET;
   logic [lcr_pkg::SCALE_WIDTH-1:0]       inv_scale_q    = lcr_pkg::SCALE_RESET;
   logic [lcr_pkg::TIMEOUT_WIDTH-1:0]     timeout_q      = lcr_pkg::TIMEOUT_RESET;

   // Predicted reader state
   reader_state_type       rd_state  = RD_IDLE;
   logic [4:0]             rd_pulses = '0;
   logic [WORD_BITS-1:0]   rd_shift  = '0;
   logic [WORD_BITS-1:0]   rd_wait   = '0;
   logic                   rd_sensor = SENSOR_DEPOSIT;

   // Stimulus and expectation stores
   tick_type    ticks_pending[$];
   reading_type readings_due[$];
   int unsigned ticks_queued   = 0;
   int unsigned ticks_taken    = 0;
   int unsigned readings_seen  = 0;
   int unsigned mismatches     = 0;

   // Pacing: percent of cycles on which each side idles
   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;
   logic        rsp_hold       = 1'b0;

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   // Subtract the latched sensor's tare, multiply by the Q16.16 reciprocal,
   // floor by 2^16 and clamp to the signed 32-bit range. The product of a
   // 25-bit difference and a 32-bit scale always fits in 64 bits.
   function automatic logic [lcr_pkg::SCALED_WIDTH-1:0] scale_reading(
         logic signed [lcr_pkg::RAW_WIDTH-1:0] raw);
      logic signed [lcr_pkg::TARE_WIDTH-1:0] tare;
      longint                                diff;
      longint                                product;
      longint                                floored;
      tare    = rd_sensor ? tare_reward_q : tare_deposit_q;
      diff    = longint'(raw) - longint'(tare);
      product = diff * $signed({32'd0, inv_scale_q});
      floored = product >>> lcr_pkg::SCALE_FRAC;
      if (floored > 64'sd2147483647)
         return lcr_pkg::SAT_MAX;
      if (floored < -64'sd2147483648)
         return lcr_pkg::SAT_MIN;
      return floored[lcr_pkg::SCALED_WIDTH-1:0];
   endfunction

   // Advance the predicted reader by one tick and return the response it owes.
   function automatic reading_type advance_reader(tick_type t);
      reading_type r;
      r = '0;
      case (rd_state)
         RD_WAIT: begin
            if (!t.level) begin
               rd_state = RD_HIGH;
               r.sck    = 1'b1;
            end else if (rd_wait >= timeout_q) begin
               rd_state = RD_IDLE;
               r.done   = 1'b1;
               r.tmo    = 1'b1;
               r.scaled = scale_reading('0);
            end else begin
               rd_wait = rd_wait + 1'b1;
            end
         end
         RD_HIGH: begin
            rd_shift  = {rd_shift[WORD_BITS-2:0], t.level};
            rd_pulses = rd_pulses + 1'b1;
            rd_state  = RD_LOW;
         end
         RD_LOW: begin
            r.sck    = 1'b1;
            rd_state = (rd_pulses < WORD_BITS) ? RD_HIGH : RD_GAIN;
         end
         RD_GAIN: begin
            rd_state = RD_IDLE;
            r.done   = 1'b1;
            r.raw    = rd_shift;
            r.scaled = scale_reading(rd_shift);
         end
         default: begin
            rd_state = RD_IDLE;
            if (t.kind == TICK_START) begin
               rd_sensor = t.sensor;
               rd_pulses = '0;
               rd_shift  = '0;
               rd_wait   = '0;
               rd_state  = RD_WAIT;
            end
         end
      endcase
      r.busy = (rd_state != RD_IDLE);
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Driver: offer pending ticks, predict each one as it is accepted
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            readings_due.push_back(advance_reader('{req_type, req_sensor_select,
                                                    req_data_level}));
            ticks_taken++;
         end
         // Hold the current request until it is taken; only then advance.
         if (!req_valid || req_ready) begin
            if (ticks_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               nxt = ticks_pending.pop_front();
               req_type          <= nxt.kind;
               req_sensor_select <= nxt.sensor;
               req_data_level    <= nxt.level;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: check each accepted response against the oldest prediction
   // --------------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = readings_due.pop_front();
               if (rsp_serial_clock !== want.sck)
                  report_mismatch($sformatf("response %0d serial_clock got %b want %b",
                                            readings_seen, rsp_serial_clock, want.sck));
               if (rsp_busy_res !== want.busy)
                  report_mismatch($sformatf("response %0d busy_res got %b want %b",
                                            readings_seen, rsp_busy_res, want.busy));
               if (rsp_done_res !== want.done)
                  report_mismatch($sformatf("response %0d done_res got %b want %b",
                                            readings_seen, rsp_done_res, want.done));
               if (rsp_timed_out !== want.tmo)
                  report_mismatch($sformatf("response %0d timed_out got %b want %b",
                                            readings_seen, rsp_timed_out, want.tmo));
               if (rsp_raw_value !== want.raw)
                  report_mismatch($sformatf("response %0d raw_value got %h want %h",
                                            readings_seen, rsp_raw_value, want.raw));
               if (rsp_scaled_value !== want.scaled)
                  report_mismatch($sformatf("response %0d scaled_value got %h want %h",
                                            readings_seen, rsp_scaled_value, want.scaled));
            end
            readings_seen++;
         end
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // --------------------------------------------------------------------------
   // Back-pressure: once traffic is flowing, hold the response side off for a
   // long stretch while the driver keeps offering, so the unit fills and
   // drops req_ready.
   // --------------------------------------------------------------------------
   initial begin
      while (ticks_taken < 20)
         @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (150) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic push_tick(logic kind, logic sensor, logic level);
      ticks_pending.push_back('{kind, sensor, level});
      ticks_queued++;
   endtask

   // Start request arriving while a read is in progress; must be ignored.
   function automatic logic stray_kind();
      return ($urandom_range(0, 3) == 0) ? TICK_START : TICK_PLAIN;
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return 24'($signed($urandom_range(0, 64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   // One complete conversion: start, a few not-ready ticks, data ready, then
   // 24 sample/low tick pairs (MSB first) and the gain pulse.
   task automatic queue_read(logic sensor, logic [WORD_BITS-1:0] word,
                             int unsigned not_ready);
      int i;
      push_tick(TICK_START, sensor, 1'($urandom));
      repeat (not_ready) push_tick(stray_kind(), 1'($urandom), 1'b1);
      push_tick(stray_kind(), 1'($urandom), 1'b0);
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         push_tick(stray_kind(), 1'($urandom), word[i]);
         push_tick(stray_kind(), 1'($urandom), 1'($urandom));
      end
      push_tick(stray_kind(), 1'($urandom), 1'($urandom));
   endtask

   // Data line never goes low: the read gives up after timeout + 1 high ticks.
   task automatic queue_timeout(logic sensor);
      push_tick(TICK_START, sensor, 1'($urandom));
      repeat (int'(timeout_q) + 1) push_tick(stray_kind(), 1'($urandom), 1'b1);
   endtask

   task automatic queue_idle(int unsigned n);
      repeat (n) push_tick(TICK_PLAIN, 1'($urandom), 1'($urandom));
   endtask

   // Unstructured ticks, then enough data-low plain ticks to finish any read
   // left running so the phase ends with the reader idle.
   task automatic queue_scramble(int unsigned n);
      repeat (n)
         push_tick(($urandom_range(0, 7) == 0) ? TICK_START : TICK_PLAIN,
                   1'($urandom), 1'($urandom));
      repeat (2 * WORD_BITS + 2) push_tick(TICK_PLAIN, 1'($urandom), 1'b0);
   endtask

   function automatic int unsigned safe_not_ready();
      return $urandom_range(0, (timeout_q < 6) ? int'(timeout_q) : 6);
   endfunction

   // Block until every queued tick is taken and every response checked.
   task automatic drain();
      while (ticks_taken != ticks_queued || readings_due.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index,
                                 logic [lcr_pkg::CSR_DATA_WIDTH-1:0] value);
      logic [lcr_pkg::CSR_DATA_WIDTH-1:0] readback_want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      readback_want = value;
      case (index)
         lcr_pkg::REG_TARE_DEPOSIT: begin
            tare_deposit_q = value[lcr_pkg::TARE_WIDTH-1:0];
            readback_want  = 32'(value[lcr_pkg::TARE_WIDTH-1:0]);
         end
         lcr_pkg::REG_TARE_REWARD: begin
            tare_reward_q = value[lcr_pkg::TARE_WIDTH-1:0];
            readback_want = 32'(value[lcr_pkg::TARE_WIDTH-1:0]);
         end
         lcr_pkg::REG_INVERSE_SCALE: begin
            inv_scale_q = value;
         end
         lcr_pkg::REG_TIMEOUT_TICKS: begin
            timeout_q     = value[lcr_pkg::TIMEOUT_WIDTH-1:0];
            readback_want = 32'(value[lcr_pkg::TIMEOUT_WIDTH-1:0]);
         end
         default: ;
      endcase
      // Address still points at the register just written
      @(negedge clock);
      if (csr_prdata !== readback_want)
         report_mismatch($sformatf("register %0d reads %h want %h",
                                   index, csr_prdata, readback_want));
   endtask

   // Write all four registers; junk in the unused upper byte of the 24-bit
   // registers must be dropped.
   task automatic configure(logic [23:0] tare0, logic [23:0] tare1,
                            logic [31:0] scale, logic [23:0] limit);
      write_register(lcr_pkg::REG_TARE_DEPOSIT,  {8'($urandom), tare0});
      write_register(lcr_pkg::REG_TARE_REWARD,   {8'($urandom), tare1});
      write_register(lcr_pkg::REG_INVERSE_SCALE, scale);
      write_register(lcr_pkg::REG_TIMEOUT_TICKS, {8'($urandom), limit});
   endtask

   // --------------------------------------------------------------------------
   // Test sequence
   // --------------------------------------------------------------------------
   initial begin
      int          ph;
      int unsigned budget;
      int unsigned pick;
      int unsigned n;
      logic [23:0] tare0;
      logic [23:0] tare1;
      logic [31:0] scale;
      logic [23:0] limit;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily
      send_gap_pct   = 16;
      recv_stall_pct = 73;

      // Reset registers: word extremes on both sensors, stray starts while busy.
      queue_idle(3);
      queue_read(SENSOR_DEPOSIT, 24'h000000, 0);
      queue_read(SENSOR_REWARD,  24'h7FFFFF, 3);
      queue_read(SENSOR_DEPOSIT, 24'h800000, 6);
      queue_read(SENSOR_REWARD,  24'hFFFFFF, 1);
      queue_read(SENSOR_DEPOSIT, 24'h000001, 2);
      queue_idle(2);
      drain();

      // Tare extremes, full-scale reciprocal, zero timeout: saturate both ways
      // and time out on the first high tick.
      configure(24'h800000, 24'h7FFFFF, 32'hFFFF_FFFF, 24'd0);
      queue_read(SENSOR_DEPOSIT, 24'h7FFFFF, 0);
      queue_read(SENSOR_REWARD,  24'h800000, 0);
      queue_timeout(SENSOR_DEPOSIT);
      queue_timeout(SENSOR_REWARD);
      queue_idle(2);
      drain();

      // Zero scale, timeout of one tick
      configure(24'h7FFFFF, 24'h800000, 32'd0, 24'd1);
      queue_read(SENSOR_REWARD, 24'h123456, 1);
      queue_timeout(SENSOR_DEPOSIT);
      queue_timeout(SENSOR_REWARD);
      drain();

      // Smallest nonzero scale rounds negatives down; longest timeout.
      configure(24'h000005, 24'hFFFFFB, 32'd1, 24'hFFFFFF);
      queue_read(SENSOR_DEPOSIT, 24'hFFFFFF, 4);
      queue_read(SENSOR_REWARD,  24'h000000, 0);
      queue_scramble(20);
      drain();

      // Random phases: each gets a fresh register set, mostly whole reads
      // with random content, plus timeouts, idle noise and scrambled ticks.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES / 3) begin
            send_gap_pct   = 73;
            recv_stall_pct = 16;
         end else if (ph == 2 * RANDOM_PHASES / 3) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         tare0 = ($urandom_range(0, 3) == 0) ? pick_word() : 24'($urandom);
         tare1 = ($urandom_range(0, 3) == 0) ? pick_word() : 24'($urandom);
         case ($urandom_range(0, 5))
            0:       scale = 32'd0;
            1:       scale = 32'hFFFF_FFFF;
            2:       scale = lcr_pkg::SCALE_RESET;
            3:       scale = $urandom_range(1, 32'h3FFFF);
            default: scale = $urandom;
         endcase
         limit = ($urandom_range(0, 3) == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 40));
         configure(tare0, tare1, scale, limit);

         budget = 0;
         while (budget < PHASE_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               queue_read(1'($urandom), pick_word(), safe_not_ready());
               budget += 2 * WORD_BITS + 2;
            end else if (pick < 75) begin
               if (timeout_q <= 40) begin
                  queue_timeout(1'($urandom));
                  budget += timeout_q + 2;
               end
            end else if (pick < 85) begin
               queue_idle($urandom_range(1, 6));
            end else begin
               n = $urandom_range(5, 60);
               queue_scramble(n);
               budget += n;
            end
         end
         drain();
      end

      if (readings_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", readings_due.size()));

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
